>>> hw/rtl/rrli_pkg.sv
`default_nettype none

package rrli_pkg;

    // list geometry
    localparam int LISTS  = 4;
    localparam int DEPTH  = 64;
    localparam int LIST_W = $clog2(LISTS);
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int ADDR_W = LIST_W + PTR_W;

    // field widths
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 2;
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 2;

    // request kinds
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_NEXT   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic do_append;
        logic do_next;
        logic load_result;
    } rrli_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } rrli_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/rrli_ctrl.sv
`default_nettype none

module rrli_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 req_type,
    output logic                      s_tready,
    input  wire rrli_pkg::rrli_stat_t stat,
    output rrli_pkg::rrli_cmd_t       cmd
);
    import rrli_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // take a beat only when idle and the output register can hold a result
    assign s_tready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    // commands
    always_comb
    begin
        cmd.do_append   = accept && (req_type == REQ_APPEND);
        cmd.do_next     = accept && (req_type == REQ_NEXT);
        cmd.load_result = (state_reg == ST_READ);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_NEXT))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rrli_datapath.sv
`default_nettype none

module rrli_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rrli_pkg::rrli_cmd_t           cmd,
    output rrli_pkg::rrli_stat_t               stat,
    input  wire logic [rrli_pkg::INDEX_W-1:0]  list_index,
    input  wire logic [rrli_pkg::VALUE_W-1:0]  in_value,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [rrli_pkg::VALUE_W-1:0]       out_value,
    output logic                               out_valid,
    output logic                               more_left
);
    import rrli_pkg::*;

    logic [VALUE_W-1:0] mem [0:LISTS*DEPTH-1];
    logic [VALUE_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]  wr_cnt_reg [0:LISTS-1];
    logic [CNT_W-1:0]  rd_cnt_reg [0:LISTS-1];
    logic [LIST_W-1:0] last_reg;
    logic              found_reg;

    logic [LISTS-1:0]  unread;
    logic [LIST_W-1:0] wr_list;
    logic              wr_ok;
    logic [LIST_W-1:0] pick;
    logic              pick_found;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    logic              out_vld_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic              out_valid_reg;
    logic              more_left_reg;

    // lists with unread values
    always_comb
    begin
        for (int l = 0; l < LISTS; l++)
        begin
            unread[l] = rd_cnt_reg[l] < wr_cnt_reg[l];
        end
    end

    // append target and room check
    assign wr_list = list_index[LIST_W-1:0];
    assign wr_ok   = (int'(list_index) < LISTS)
                     && (wr_cnt_reg[wr_list] < CNT_W'(DEPTH));
    assign wr_addr = {wr_list, wr_cnt_reg[wr_list][PTR_W-1:0]};

    // rotating priority pick, starting after the last served list
    always_comb
    begin
        logic [LIST_W-1:0] cand;
        pick       = last_reg;
        pick_found = 1'b0;
        for (int s = 1; s <= LISTS; s++)
        begin
            cand = last_reg + LIST_W'(s);
            if (!pick_found && unread[cand])
            begin
                pick       = cand;
                pick_found = 1'b1;
            end
        end
    end

    assign rd_addr = {pick, rd_cnt_reg[pick][PTR_W-1:0]};

    // list store
    always_ff @(posedge clk)
    begin
        if (cmd.do_append && wr_ok)
        begin
            mem[wr_addr] <= in_value;
        end
        if (cmd.do_next)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // counters and round-robin pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LISTS; l++)
            begin
                wr_cnt_reg[l] <= '0;
                rd_cnt_reg[l] <= '0;
            end
            last_reg  <= LIST_W'(LISTS - 1);
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_append && wr_ok)
            begin
                wr_cnt_reg[wr_list] <= wr_cnt_reg[wr_list] + CNT_W'(1);
            end
            if (cmd.do_next)
            begin
                found_reg <= pick_found;
                if (pick_found)
                begin
                    rd_cnt_reg[pick] <= rd_cnt_reg[pick] + CNT_W'(1);
                    last_reg         <= pick;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_value_reg <= found_reg ? rd_data_reg : '0;
            out_valid_reg <= found_reg;
            more_left_reg <= |unread;
        end
    end

    assign stat.out_free = !out_vld_reg || m_tready;
    assign m_tvalid      = out_vld_reg;
    assign out_value     = out_value_reg;
    assign out_valid     = out_valid_reg;
    assign more_left     = more_left_reg;

endmodule

`default_nettype wire

>>> hw/rtl/round_robin_list_interleaver.sv
// round_robin_list_interleaver
//
// Keeps four lists of signed 32-bit values, 64 entries each, and serves
// them back in round-robin order.
// Input channel s_*: s_tuser is req_type (0 append, 1 next); s_tdata holds
// list_index in [1:0] and in_value in [33:2]. An append beat stores its
// value at the tail of the list and gives no result; appends to a full
// list are dropped.
// Output channel m_*: one beat per next request; m_tdata is out_value,
// m_tuser holds out_valid in [0] and more_left in [1]. With no unread
// value left the beat carries out_valid 0 and value 0.
// A next holds s_tready low in ST_READ, set by the registered read port of
// the list store; an append does not. The result of a next passes through
// rd_data_reg and then the output register before it shows on m_tvalid.
// Reset empties all lists and restarts the round robin at list 0.
// When the receiver stalls, the result waits in the output register and
// s_tready drops until that beat is taken.

`default_nettype none

module round_robin_list_interleaver (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rrli_pkg::S_DATA_W-1:0]  s_tdata,  // list_index, in_value
    input  wire logic [rrli_pkg::S_USER_W-1:0]  s_tuser,  // req_type
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [rrli_pkg::M_DATA_W-1:0]       m_tdata,  // out_value
    output logic [rrli_pkg::M_USER_W-1:0]       m_tuser   // out_valid, more_left
);
    import rrli_pkg::*;

    rrli_cmd_t  cmd;
    rrli_stat_t stat;
    logic       out_valid;
    logic       more_left;

    // controller
    rrli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser[0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    rrli_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .list_index (s_tdata[INDEX_W-1:0]),
        .in_value   (s_tdata[INDEX_W +: VALUE_W]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_value  (m_tdata),
        .out_valid  (out_valid),
        .more_left  (more_left)
    );

    assign m_tuser = {more_left, out_valid};

endmodule

`default_nettype wire

>>> hw/rtl/rrli_checker.sv
`default_nettype none

module rrli_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [rrli_pkg::S_USER_W-1:0] s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [rrli_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic [rrli_pkg::M_USER_W-1:0] m_tuser
);
    import rrli_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // an empty answer carries value zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("empty answer with nonzero value");

    // an empty answer means nothing is left
    a_empty_none_left: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> !m_tuser[1])
        else $error("empty answer reports values left");

    // an append beat gives no result
    a_append_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == REQ_APPEND) |=> !$rose(m_tvalid))
        else $error("append produced a result");

endmodule

bind round_robin_list_interleaver rrli_checker u_rrli_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> sim/round_robin_list_interleaver_tb.sv
`timescale 1ns / 100ps

module round_robin_list_interleaver_tb;

    import rrli_pkg::*;

    // one result beat as seen on m_tdata / m_tuser
    typedef struct packed {
        logic [VALUE_W-1:0] pick_value;
        logic               pick_valid;
        logic               pick_more;
    } pick_t;

    // directed stimulus row; fixed_res marks a hand-written expectation
    typedef struct packed {
        logic               req;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        logic               fixed_res;
        pick_t              res;
    } dir_row_t;

    localparam int DIR_ROWS     = 21;
    localparam int RANDOM_ITEMS = 575;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    // shadow copy of the list store and its pointers
    logic [VALUE_W-1:0] shadow_lists [LISTS][DEPTH];
    logic [CNT_W-1:0]   wr_cnt [LISTS];
    logic [CNT_W-1:0]   rd_cnt [LISTS];
    logic [LIST_W-1:0]  last_pick;

    pick_t pending_picks [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_cnt  = 0;
    int n_append      = 0;
    int n_dropped     = 0;
    int n_next        = 0;
    int n_served      = 0;
    int n_empty       = 0;
    int n_checked     = 0;

    // directed rows: empty at reset, extremes on every list, wrap, late append
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{REQ_NEXT,   2'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
        '{REQ_APPEND, 2'd0, 32'h7fff_ffff, 1'b0, '0},
        '{REQ_APPEND, 2'd1, 32'h8000_0000, 1'b0, '0},
        '{REQ_APPEND, 2'd2, 32'hffff_ffff, 1'b0, '0},
        '{REQ_APPEND, 2'd3, 32'h0000_0000, 1'b0, '0},
        '{REQ_APPEND, 2'd0, 32'h0000_0001, 1'b0, '0},
        '{REQ_APPEND, 2'd1, 32'h5555_5555, 1'b0, '0},
        '{REQ_APPEND, 2'd3, 32'haaaa_aaaa, 1'b0, '0},
        '{REQ_NEXT,   2'd3, 32'hffff_ffff, 1'b1, '{32'h7fff_ffff, 1'b1, 1'b1}},
        '{REQ_NEXT,   2'd0, 32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b1, 1'b1}},
        '{REQ_NEXT,   2'd1, 32'h1234_5678, 1'b1, '{32'hffff_ffff, 1'b1, 1'b1}},
        '{REQ_NEXT,   2'd2, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b1}},
        '{REQ_NEXT,   2'd0, 32'h0000_0000, 1'b0, '0},
        '{REQ_APPEND, 2'd2, 32'h1234_5678, 1'b0, '0},
        '{REQ_NEXT,   2'd0, 32'h0000_0000, 1'b0, '0},
        '{REQ_NEXT,   2'd0, 32'h0000_0000, 1'b0, '0},
        '{REQ_NEXT,   2'd0, 32'h0000_0000, 1'b0, '0},
        '{REQ_NEXT,   2'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
        '{REQ_APPEND, 2'd3, 32'hffff_fffe, 1'b0, '0},
        '{REQ_NEXT,   2'd0, 32'h0000_0000, 1'b0, '0},
        '{REQ_NEXT,   2'd2, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}}
    };

    round_robin_list_interleaver u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic bit list_full(input logic [INDEX_W-1:0] idx);
        return wr_cnt[idx] >= DEPTH;
    endfunction

    // advance the shadow lists by one request; returns 1 when a result beat is due
    function automatic bit interleave_step(input logic req, input logic [INDEX_W-1:0] idx,
                                           input logic [VALUE_W-1:0] val, output pick_t res);
        int  cand;
        bit  found;
        res   = '0;
        found = 1'b0;
        if (req == REQ_APPEND)
        begin
            if (idx < LISTS && wr_cnt[idx] < DEPTH)
            begin
                shadow_lists[idx][wr_cnt[idx][PTR_W-1:0]] = val;
                wr_cnt[idx] = wr_cnt[idx] + CNT_W'(1);
            end
            return 1'b0;
        end
        // rotating search starting after the list served last
        for (int s = 1; s <= LISTS; s++)
        begin
            cand = (int'(last_pick) + s) % LISTS;
            if (!found && rd_cnt[cand] < wr_cnt[cand])
            begin
                res.pick_value = shadow_lists[cand][rd_cnt[cand][PTR_W-1:0]];
                res.pick_valid = 1'b1;
                rd_cnt[cand]   = rd_cnt[cand] + CNT_W'(1);
                last_pick      = LIST_W'(cand);
                found          = 1'b1;
            end
        end
        for (int l = 0; l < LISTS; l++)
        begin
            if (rd_cnt[l] < wr_cnt[l])
                res.pick_more = 1'b1;
        end
        return 1'b1;
    endfunction

    // offer one beat, wait for acceptance, then record what it should produce
    task automatic push_beat(input logic req, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val, input logic fixed_res,
                             input pick_t fixed_pick);
        pick_t model_pick;
        bit    has_res;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(S_DATA_W - VALUE_W - INDEX_W){1'b0}}, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (req == REQ_APPEND)
        begin
            n_append++;
            if (list_full(idx))
                n_dropped++;
        end
        else
        begin
            n_next++;
        end
        has_res = interleave_step(req, idx, val, model_pick);
        if (has_res)
        begin
            if (model_pick.pick_valid)
                n_served++;
            else
                n_empty++;
            pending_picks = {pending_picks, (fixed_res ? fixed_pick : model_pick)};
        end
        // random gap after the beat
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // hold the sender off until every pending result has come back
    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
    endtask

    // bursts of appends (biased towards list 3 so it fills) and bursts of next requests
    task automatic run_random(input int n_items);
        int                 done;
        int                 burst;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        done = 0;
        while (done < n_items)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 10);
                repeat (burst)
                begin
                    idx = ($urandom_range(0, 99) < 40) ? INDEX_W'(3)
                                                       : INDEX_W'($urandom_range(0, 3));
                    case ($urandom_range(0, 9))
                        0:       val = 32'h7fff_ffff;
                        1:       val = 32'h8000_0000;
                        2:       val = 32'hffff_ffff;
                        default: val = $urandom;
                    endcase
                    if (!list_full(idx))
                        done++;
                    push_beat(REQ_APPEND, idx, val, 1'b0, '0);
                end
            end
            else
            begin
                burst = $urandom_range(1, 8);
                repeat (burst)
                begin
                    push_beat(REQ_NEXT, INDEX_W'($urandom), $urandom, 1'b0, '0);
                    done++;
                end
            end
        end
    endtask

    // receiver: random back-pressure and check of every result beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_picks.size() == 0)
                begin
                    $error("result beat with nothing pending: out_value %h", m_tdata);
                    mismatch_cnt++;
                end
                else
                begin
                    pick_t want;
                    want = pending_picks.pop_front();
                    n_checked++;
                    if (m_tdata !== want.pick_value)
                    begin
                        $error("out_value: expected %h, got %h", want.pick_value, m_tdata);
                        mismatch_cnt++;
                    end
                    if (m_tuser[0] !== want.pick_valid)
                    begin
                        $error("out_valid: expected %b, got %b", want.pick_valid, m_tuser[0]);
                        mismatch_cnt++;
                    end
                    if (m_tuser[1] !== want.pick_more)
                    begin
                        $error("more_left: expected %b, got %b", want.pick_more, m_tuser[1]);
                        mismatch_cnt++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // main sequence
    initial
    begin
        for (int l = 0; l < LISTS; l++)
        begin
            wr_cnt[l] = '0;
            rd_cnt[l] = '0;
        end
        last_pick = LIST_W'(LISTS - 1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows with light idling on both sides
        send_idle_pct = 20;
        recv_idle_pct = 20;
        for (int r = 0; r < DIR_ROWS; r++)
            push_beat(dir_rows[r].req, dir_rows[r].idx, dir_rows[r].val,
                      dir_rows[r].fixed_res, dir_rows[r].res);
        drain_results();

        // slow sender, mostly stalled receiver
        send_idle_pct = 36;
        recv_idle_pct = 85;
        run_random(RANDOM_ITEMS);
        drain_results();

        // mostly idle sender, receiver stalled now and then
        send_idle_pct = 85;
        recv_idle_pct = 36;
        run_random(RANDOM_ITEMS);
        drain_results();

        // back to back in both directions
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_ITEMS);
        drain_results();
        repeat (20) @(posedge clk);

        $display("covered %0d appends (%0d refused on a full list) and %0d next requests",
                 n_append, n_dropped, n_next);
        $display("%0d values served, %0d requests found all lists empty, %0d beats checked",
                 n_served, n_empty, n_checked);
        if (mismatch_cnt == 0 && pending_picks.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rrli_pkg.sv
hw/rtl/rrli_ctrl.sv
hw/rtl/rrli_datapath.sv
hw/rtl/round_robin_list_interleaver.sv
hw/rtl/rrli_checker.sv
sim/round_robin_list_interleaver_tb.sv
